[sv/vsfr_pkg.sv]
// ----------------------------------------------------------------------------
// vsfr_pkg
// Shared types, widths and codes of the video slice frame reassembler.
// ----------------------------------------------------------------------------
package vsfr_pkg;

   localparam int SLOTS     = 64;
   localparam int IDX_W     = $clog2(SLOTS);
   localparam int FID_W     = 32;
   localparam int SEQ_W     = 6;
   localparam int SSZ_W     = 11;
   localparam int FSZ_W     = 17;
   localparam int STAT_W    = 3;
   localparam int CNT_OUT_W = 7;

   // Accumulators are at least as wide as the output fields they feed.
   localparam int SUM_RAW_W = IDX_W + SSZ_W;
   localparam int SUM_W     = (SUM_RAW_W > FSZ_W) ? SUM_RAW_W : FSZ_W;
   localparam int CNT_RAW_W = $clog2(SLOTS + 1);
   localparam int CNT_W     = (CNT_RAW_W > CNT_OUT_W) ? CNT_RAW_W : CNT_OUT_W;

   localparam logic [FSZ_W-1:0]     LEN_MAX = {FSZ_W{1'b1}};
   localparam logic [CNT_OUT_W-1:0] CNT_MAX = {CNT_OUT_W{1'b1}};

   typedef enum logic [STAT_W-1:0] {
      STAT_STORED  = 3'd0,
      STAT_DUP     = 3'd1,
      STAT_STALE   = 3'd2,
      STAT_RESYNC  = 3'd3,
      STAT_RESTART = 3'd4,
      STAT_DONE    = 3'd5
   } vsfr_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_FINISH
   } vsfr_state_type;

   typedef struct packed {
      logic [FID_W-1:0] frame_id;
      logic [SSZ_W-1:0] slice_size;
      logic [FSZ_W-1:0] frame_size;
   } vsfr_entry_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] index;
   } vsfr_clear_type;

   typedef struct packed {
      logic                 complete;
      logic [FSZ_W-1:0]     length;
      logic [CNT_OUT_W-1:0] count;
      logic [FID_W-1:0]     frame_id;
   } vsfr_result_type;

   typedef struct packed {
      vsfr_status_type      status;
      logic                 frame_done;
      logic [FSZ_W-1:0]     frame_length;
      logic [FID_W-1:0]     done_frame_id;
      logic [CNT_OUT_W-1:0] slice_count;
   } vsfr_rsp_type;

endpackage

[sv/vsfr_ram.sv]
// ----------------------------------------------------------------------------
// vsfr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module vsfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/vsfr_scan.sv]
// ----------------------------------------------------------------------------
// vsfr_scan
// Walks the slot table from slot 0, drops the first stale slot of the leading
// run and sums slice sizes and counts for the completion check.
// ----------------------------------------------------------------------------
module vsfr_scan import vsfr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [FID_W-1:0] expected_id,
   input  vsfr_entry_type   rd_entry,
   output logic [IDX_W-1:0] rd_addr,
   output vsfr_clear_type   clr,
   output logic             done,
   output vsfr_result_type  result
);

   logic             running_ff, running_in;
   logic [IDX_W:0]   issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic             clean_act_ff, clean_act_in;
   logic             sum_act_ff, sum_act_in;
   logic             len_act_ff, len_act_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [FSZ_W-1:0] fsz0_ff, fsz0_in;
   logic [FID_W-1:0] id0_ff, id0_in;
   logic             done_ff;

   vsfr_entry_type   eff;
   logic             clr_hit;
   logic             last;
   logic             issuing;

   always_comb begin
      // A slot cleared here reads as empty for the sums that follow.
      clr_hit = pend_ff && clean_act_ff && (rd_entry.slice_size != '0) &&
                (rd_entry.frame_id != expected_id);
      eff     = clr_hit ? '0 : rd_entry;

      clean_act_in = clean_act_ff;
      sum_act_in   = sum_act_ff;
      len_act_in   = len_act_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      fsz0_in      = fsz0_ff;
      id0_in       = id0_ff;

      if (pend_ff) begin
         if ((rd_entry.slice_size == '0) || clr_hit) begin
            clean_act_in = 1'b0;
         end
         if (sum_act_ff) begin
            if (eff.slice_size == '0) begin
               sum_act_in = 1'b0;
            end else begin
               sum_in = sum_ff + SUM_W'(eff.slice_size);
            end
         end
         if (len_act_ff) begin
            if (eff.frame_size == '0) begin
               len_act_in = 1'b0;
            end else begin
               len_in = len_ff + SUM_W'(eff.slice_size);
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         if (pend_idx_ff == '0) begin
            fsz0_in = eff.frame_size;
            id0_in  = eff.frame_id;
         end
      end

      last = pend_ff && ((!sum_act_in && !len_act_in) ||
                         (pend_idx_ff == IDX_W'(SLOTS - 1)));

      issuing     = running_ff && !last && (issue_ff < (IDX_W + 1)'(SLOTS));
      rd_addr     = issue_ff[IDX_W-1:0];
      pend_in     = issuing;
      pend_idx_in = issue_ff[IDX_W-1:0];
      issue_in    = issue_ff + (IDX_W + 1)'(issuing);
      running_in  = running_ff && !last;

      if (start) begin
         running_in   = 1'b1;
         issue_in     = '0;
         pend_in      = 1'b0;
         clean_act_in = 1'b1;
         sum_act_in   = 1'b1;
         len_act_in   = 1'b1;
         sum_in       = '0;
         len_in       = '0;
         cnt_in       = '0;
         fsz0_in      = '0;
         id0_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         done_ff      <= 1'b0;
         issue_ff     <= '0;
         clean_act_ff <= 1'b0;
         sum_act_ff   <= 1'b0;
         len_act_ff   <= 1'b0;
      end else begin
         running_ff   <= running_in;
         pend_ff      <= pend_in;
         done_ff      <= last;
         issue_ff     <= issue_in;
         clean_act_ff <= clean_act_in;
         sum_act_ff   <= sum_act_in;
         len_act_ff   <= len_act_in;
      end
      pend_idx_ff <= pend_idx_in;
      sum_ff      <= sum_in;
      len_ff      <= len_in;
      cnt_ff      <= cnt_in;
      fsz0_ff     <= fsz0_in;
      id0_ff      <= id0_in;
   end

   assign clr.valid = clr_hit;
   assign clr.index = pend_idx_ff;
   assign done      = done_ff;

   assign result.complete = (fsz0_ff != '0) && (sum_ff == SUM_W'(fsz0_ff));
   assign result.length   = (len_ff > SUM_W'(LEN_MAX)) ? LEN_MAX : FSZ_W'(len_ff);
   assign result.count    = (cnt_ff > CNT_W'(CNT_MAX)) ? CNT_MAX : CNT_OUT_W'(cnt_ff);
   assign result.frame_id = id0_ff;

endmodule

[sv/video_slice_frame_reassembler.sv]
// ----------------------------------------------------------------------------
// video_slice_frame_reassembler
// Slot table of received slice headers with frame completion detection.
// ----------------------------------------------------------------------------
// Each request word carries one slice header and produces exactly one response
// word. A word that is dropped goes from acceptance through the decide and
// finish states to its response; a stored slice adds a walk over the slot table
// held in a single read port RAM, one slot per cycle, ending at the end of the
// filled run. Slot valid bits live in flip-flops, so the table is cleared in a
// single step after a completed frame and no clearing pass is needed after
// reset. A finished response waits in an output register while the next
// request word is accepted.
module video_slice_frame_reassembler import vsfr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FID_W-1:0]     req_frame_id,
   input  logic [SEQ_W-1:0]     req_slice_seq,
   input  logic [SSZ_W-1:0]     req_slice_size,
   input  logic [FSZ_W-1:0]     req_frame_size,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STAT_W-1:0]    rsp_status,
   output logic                 rsp_frame_done,
   output logic [FSZ_W-1:0]     rsp_frame_length,
   output logic [FID_W-1:0]     rsp_done_frame_id,
   output logic [CNT_OUT_W-1:0] rsp_slice_count
);

   vsfr_state_type   state_ff, state_in;
   logic [FID_W-1:0] expected_ff, expected_in;
   logic [SLOTS-1:0] slot_valid_ff, slot_valid_in;
   vsfr_entry_type   req_ff;
   logic [SEQ_W-1:0] seq_ff;
   vsfr_rsp_type     pend_ff, pend_in;
   vsfr_rsp_type     rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             valid_rd_ff;

   logic             accept;
   logic             store_en;
   logic [IDX_W-1:0] wr_idx;
   logic             scan_start;
   logic [IDX_W-1:0] rd_addr;
   vsfr_entry_type   ram_rd;
   vsfr_entry_type   rd_entry;
   vsfr_clear_type   scan_clr;
   logic             scan_done;
   vsfr_result_type  scan_res;

   assign accept   = req_valid && !req_stall;
   assign wr_idx   = IDX_W'(seq_ff);
   assign rd_entry = valid_rd_ff ? ram_rd : '0;

   always_comb begin
      state_in      = state_ff;
      expected_in   = expected_ff;
      slot_valid_in = slot_valid_ff;
      pend_in       = pend_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      store_en      = 1'b0;
      scan_start    = 1'b0;
      req_stall     = (state_ff != S_IDLE);

      if (scan_clr.valid) begin
         slot_valid_in[scan_clr.index] = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            pend_in        = '0;
            pend_in.status = STAT_STALE;
            priority if (32'(seq_ff) >= SLOTS) begin
               pend_in.status = STAT_STALE;
            end else if (req_ff.frame_id == expected_ff) begin
               if (slot_valid_ff[wr_idx]) begin
                  pend_in.status = STAT_DUP;
               end else begin
                  pend_in.status = STAT_STORED;
                  store_en       = 1'b1;
               end
            end else if (req_ff.frame_id == '0) begin
               pend_in.status = STAT_RESTART;
               store_en       = 1'b1;
               expected_in    = '0;
            end else if (expected_ff == '0) begin
               pend_in.status = STAT_RESYNC;
               expected_in    = req_ff.frame_id + FID_W'(2);
            end else begin
               pend_in.status = STAT_STALE;
            end
            if (store_en) begin
               slot_valid_in[wr_idx] = 1'b1;
               scan_start            = 1'b1;
               state_in              = S_SCAN;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               if (scan_res.complete) begin
                  pend_in.status        = STAT_DONE;
                  pend_in.frame_done    = 1'b1;
                  pend_in.frame_length  = scan_res.length;
                  pend_in.done_frame_id = scan_res.frame_id;
                  pend_in.slice_count   = scan_res.count;
                  expected_in           = scan_res.frame_id + FID_W'(1);
                  slot_valid_in         = '0;
               end
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // The output register frees up when its word is taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         expected_ff   <= '0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         expected_ff   <= expected_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (accept) begin
         req_ff.frame_id   <= req_frame_id;
         req_ff.slice_size <= req_slice_size;
         req_ff.frame_size <= req_frame_size;
         seq_ff            <= req_slice_seq;
      end
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
      valid_rd_ff <= slot_valid_ff[rd_addr];
   end

   vsfr_ram #(
      .WIDTH ($bits(vsfr_entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (wr_idx),
      .wr_data (req_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   vsfr_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (scan_start),
      .expected_id (expected_ff),
      .rd_entry    (rd_entry),
      .rd_addr     (rd_addr),
      .clr         (scan_clr),
      .done        (scan_done),
      .result      (scan_res)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_frame_done    = rsp_data_ff.frame_done;
   assign rsp_frame_length  = rsp_data_ff.frame_length;
   assign rsp_done_frame_id = rsp_data_ff.done_frame_id;
   assign rsp_slice_count   = rsp_data_ff.slice_count;

   a_done_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_done == (rsp_status == STAT_DONE)))
      else $error("frame_done disagrees with status");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_done) |->
         (rsp_frame_length == '0 && rsp_done_frame_id == '0 && rsp_slice_count == '0))
      else $error("dropped slice response carries frame fields");

   a_table_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && scan_done && scan_res.complete) |=> (slot_valid_ff == '0))
      else $error("slot table not cleared after a completed frame");

   a_store_valid: assert property (@(posedge clock) disable iff (reset)
      store_en |=> slot_valid_ff[$past(wr_idx)])
      else $error("stored slot not marked valid");

   a_clear_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_clr.valid |-> (state_ff == S_SCAN))
      else $error("stale slot cleared outside a table walk");

endmodule

[verif/video_slice_frame_reassembler_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_slice_frame_reassembler_test
// Self-checking bench for the slice header reassembler. A directed table covers
// resync, restart, duplicates, stale ids, id wrap and the cleaning and
// completion rules. Random frames, restarts and noise follow. Every response
// word is checked against a local model of the slot table.
// ----------------------------------------------------------------------------
module video_slice_frame_reassembler_test import vsfr_pkg::*; ();

   localparam int N_PLAN       = 22;
   localparam int RANDOM_ITEMS = 500;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 100;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FID_W-1:0]     req_frame_id = '0;
   logic [SEQ_W-1:0]     req_slice_seq = '0;
   logic [SSZ_W-1:0]     req_slice_size = '0;
   logic [FSZ_W-1:0]     req_frame_size = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STAT_W-1:0]    rsp_status;
   logic                 rsp_frame_done;
   logic [FSZ_W-1:0]     rsp_frame_length;
   logic [FID_W-1:0]     rsp_done_frame_id;
   logic [CNT_OUT_W-1:0] rsp_slice_count;

   video_slice_frame_reassembler u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_frame_id      (req_frame_id),
      .req_slice_seq     (req_slice_seq),
      .req_slice_size    (req_slice_size),
      .req_frame_size    (req_frame_size),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_done_frame_id (rsp_done_frame_id),
      .rsp_slice_count   (rsp_slice_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Local copy of the slot table and the frame id it waits for.
   logic [FID_W-1:0] want_id;
   bit               slot_used [SLOTS];
   logic [FID_W-1:0] slot_fid  [SLOTS];
   logic [SSZ_W-1:0] slot_ssz  [SLOTS];
   logic [FSZ_W-1:0] slot_fsz  [SLOTS];

   vsfr_rsp_type verdicts [$];
   int           mismatches = 0;
   int           items_sent = 0;
   int           burst_left = 0;
   int           quiet_cycles = 0;

   function automatic void wipe_table();
      for (int i = 0; i < SLOTS; i++) begin
         slot_used[i] = 1'b0;
         slot_fid[i]  = '0;
         slot_ssz[i]  = '0;
         slot_fsz[i]  = '0;
      end
   endfunction

   function automatic void fill_slot(input logic [SEQ_W-1:0] seq, input logic [FID_W-1:0] fid,
                                     input logic [SSZ_W-1:0] ssz, input logic [FSZ_W-1:0] fsz);
      slot_used[seq] = 1'b1;
      slot_fid[seq]  = fid;
      slot_ssz[seq]  = ssz;
      slot_fsz[seq]  = fsz;
   endfunction

   function automatic vsfr_rsp_type judge_slice(input logic [FID_W-1:0] fid,
                                                input logic [SEQ_W-1:0] seq,
                                                input logic [SSZ_W-1:0] ssz,
                                                input logic [FSZ_W-1:0] fsz);
      vsfr_rsp_type r;
      int unsigned  run_sum;
      int unsigned  len;
      int unsigned  n;
      r = '0;
      if (fid == want_id) begin
         if (slot_used[seq]) begin
            r.status = STAT_DUP;
         end else begin
            fill_slot(seq, fid, ssz, fsz);
            r.status = STAT_STORED;
         end
      end else if (fid == '0) begin
         want_id = '0;
         fill_slot(seq, fid, ssz, fsz);
         r.status = STAT_RESTART;
      end else if (want_id == '0) begin
         want_id = fid + 32'd2;
         r.status = STAT_RESYNC;
      end else begin
         r.status = STAT_STALE;
      end

      if (r.status == STAT_STORED || r.status == STAT_RESTART) begin
         // Only the first leading slot with a foreign id is dropped.
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_ssz[i] == '0) break;
            if (slot_fid[i] == want_id) continue;
            slot_used[i] = 1'b0;
            slot_fid[i]  = '0;
            slot_ssz[i]  = '0;
            slot_fsz[i]  = '0;
            break;
         end
         run_sum = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_ssz[i] == '0) break;
            run_sum += slot_ssz[i];
         end
         if (slot_fsz[0] != '0 && run_sum == slot_fsz[0]) begin
            // Length and count stop at the first slot without a frame size.
            len = 0;
            n = 0;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_fsz[i] == '0) break;
               len += slot_ssz[i];
               n++;
            end
            r.status        = STAT_DONE;
            r.frame_done    = 1'b1;
            r.frame_length  = (len > LEN_MAX) ? LEN_MAX : FSZ_W'(len);
            r.slice_count   = (n > CNT_MAX) ? CNT_MAX : CNT_OUT_W'(n);
            r.done_frame_id = slot_fid[0];
            want_id = slot_fid[0] + 32'd1;
            wipe_table();
         end
      end
      return r;
   endfunction

   // Drives one slice header word and records its verdict once it is taken.
   task automatic send_slice(input logic [FID_W-1:0] fid, input logic [SEQ_W-1:0] seq,
                             input logic [SSZ_W-1:0] ssz, input logic [FSZ_W-1:0] fsz,
                             input bit typed, input vsfr_status_type typed_status);
      vsfr_rsp_type verdict;
      req_valid      <= 1'b1;
      req_frame_id   <= fid;
      req_slice_seq  <= seq;
      req_slice_size <= ssz;
      req_frame_size <= fsz;
      do @(posedge clock); while (req_stall);
      verdict = judge_slice(fid, seq, ssz, fsz);
      if (typed) begin
         verdict = '0;
         verdict.status = typed_status;
      end
      verdicts.push_back(verdict);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   task automatic note_mismatch(input string what, input logic [FID_W-1:0] want_v,
                                input logic [FID_W-1:0] got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch in %s: expected %0h, got %0h", what, want_v, got_v);
   endtask

   typedef struct {
      logic [FID_W-1:0] fid;
      logic [SEQ_W-1:0] seq;
      logic [SSZ_W-1:0] ssz;
      logic [FSZ_W-1:0] fsz;
      bit               typed;
      vsfr_status_type  status;
   } plan_row_type;

   // Rows marked typed carry a drop or restart status with all other fields zero.
   plan_row_type plan [N_PLAN] = '{
      '{32'd5,          6'd0,  11'd100,  17'd300,    1'b1, STAT_RESYNC},
      '{32'd7,          6'd0,  11'd100,  17'd300,    1'b0, STAT_STORED},
      '{32'd7,          6'd0,  11'd5,    17'd5,      1'b1, STAT_DUP},
      '{32'd3,          6'd1,  11'd200,  17'd300,    1'b1, STAT_STALE},
      '{32'd7,          6'd1,  11'd200,  17'd0,      1'b0, STAT_STORED},
      '{32'd0,          6'd2,  11'd50,   17'd50,     1'b1, STAT_RESTART},
      '{32'd0,          6'd0,  11'd1472, 17'd1472,   1'b0, STAT_STORED},
      '{32'hFFFF_FFFF,  6'd63, 11'd2047, 17'd131071, 1'b1, STAT_STALE},
      '{32'd0,          6'd63, 11'd2047, 17'd131071, 1'b1, STAT_RESTART},
      '{32'hFFFF_FFFF,  6'd0,  11'd0,    17'd0,      1'b1, STAT_RESYNC},
      '{32'd0,          6'd63, 11'd0,    17'd0,      1'b1, STAT_RESTART},
      '{32'hFFFF_FFFE,  6'd0,  11'd0,    17'd0,      1'b1, STAT_RESYNC},
      '{32'd0,          6'd0,  11'd100,  17'd500,    1'b0, STAT_STORED},
      '{32'd9,          6'd3,  11'd0,    17'd0,      1'b1, STAT_RESYNC},
      '{32'd11,         6'd1,  11'd50,   17'd50,     1'b0, STAT_STORED},
      '{32'd11,         6'd0,  11'd0,    17'd70,     1'b0, STAT_STORED},
      '{32'd11,         6'd0,  11'd9,    17'd9,      1'b1, STAT_DUP},
      '{32'd0,          6'd0,  11'd70,   17'd120,    1'b0, STAT_STORED},
      '{32'd0,          6'd1,  11'd50,   17'd120,    1'b0, STAT_STORED},
      '{32'd0,          6'd5,  11'd0,    17'd0,      1'b1, STAT_RESTART},
      '{32'hFFFF_FFFD,  6'd0,  11'd0,    17'd0,      1'b1, STAT_RESYNC},
      '{32'hFFFF_FFFF,  6'd0,  11'd2047, 17'd2047,   1'b0, STAT_STORED}
   };

   initial begin : stimulus
      logic [SSZ_W-1:0] part_ssz [SLOTS];
      logic [FSZ_W-1:0] part_fsz [SLOTS];
      int               order [SLOTS];
      int               n;
      int               j;
      int               tmp;
      int               pick;
      int               skip;
      int unsigned      total;
      logic [FID_W-1:0] fid;
      wipe_table();
      want_id = '0;
      burst_left = $urandom_range(1, 40);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < N_PLAN; k++)
         send_slice(plan[k].fid, plan[k].seq, plan[k].ssz, plan[k].fsz,
                    plan[k].typed, plan[k].status);

      while (items_sent < N_PLAN + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // A frame for the id the table waits for, sometimes broken.
            fid = want_id;
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, SLOTS) : $urandom_range(1, 6);
            total = 0;
            for (int k = 0; k < n; k++) begin
               part_ssz[k] = ($urandom_range(0, 9) == 0) ? SSZ_W'($urandom_range(1473, 2047))
                                                          : SSZ_W'($urandom_range(1, 1472));
               total += part_ssz[k];
               order[k] = k;
            end
            for (int k = 0; k < n; k++)
               part_fsz[k] = FSZ_W'(total);
            if ($urandom_range(0, 19) == 0)
               part_fsz[0] = part_fsz[0] + 1'b1;
            if (n > 1 && $urandom_range(0, 9) == 0)
               part_fsz[$urandom_range(1, n - 1)] = '0;
            if ($urandom_range(0, 1) == 1) begin
               for (int k = n - 1; k > 0; k--) begin
                  j = $urandom_range(0, k);
                  tmp = order[k];
                  order[k] = order[j];
                  order[j] = tmp;
               end
            end
            skip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
            for (int k = 0; k < n; k++) begin
               if (order[k] != skip) begin
                  send_slice(fid, SEQ_W'(order[k]), part_ssz[order[k]], part_fsz[order[k]],
                             1'b0, STAT_STORED);
                  if ($urandom_range(0, 14) == 0)
                     send_slice(fid, SEQ_W'(order[k]), part_ssz[order[k]],
                                part_fsz[order[k]], 1'b0, STAT_STORED);
               end
            end
         end else if (pick < 80) begin
            send_slice('0, SEQ_W'($urandom_range(0, SLOTS - 1)), SSZ_W'($urandom_range(0, 1472)),
                       FSZ_W'($urandom_range(0, 131071)), 1'b0, STAT_STORED);
         end else if (pick < 88) begin
            fid = $urandom;
            if (fid == '0)
               fid = 32'd1;
            send_slice(fid, SEQ_W'($urandom_range(0, SLOTS - 1)), SSZ_W'($urandom_range(1, 1472)),
                       FSZ_W'($urandom_range(1, 131071)), 1'b0, STAT_STORED);
         end else begin
            fid = ($urandom_range(0, 3) == 0) ? want_id + 32'($urandom_range(0, 2)) - 32'd1
                                              : $urandom;
            send_slice(fid, SEQ_W'($urandom_range(0, SLOTS - 1)), SSZ_W'($urandom_range(0, 2047)),
                       FSZ_W'($urandom_range(0, 131071)), 1'b0, STAT_STORED);
         end
      end

      req_valid <= 1'b0;
      while (verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // The receiver switches between open, choppy and blocked stretches.
   int stall_mode = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 20) : $urandom_range(1, 60);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_stall <= 1'b1;
            end
         endcase
      end
   end

   always @(posedge clock) begin : response_check
      vsfr_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts.size() == 0) begin
            note_mismatch("unexpected response word, status", '0, FID_W'(rsp_status));
         end else begin
            want = verdicts.pop_front();
            if (rsp_status !== want.status)
               note_mismatch("status", FID_W'(want.status), FID_W'(rsp_status));
            if (rsp_frame_done !== want.frame_done)
               note_mismatch("frame_done", FID_W'(want.frame_done), FID_W'(rsp_frame_done));
            if (rsp_frame_length !== want.frame_length)
               note_mismatch("frame_length", FID_W'(want.frame_length),
                             FID_W'(rsp_frame_length));
            if (rsp_done_frame_id !== want.done_frame_id)
               note_mismatch("done_frame_id", want.done_frame_id, rsp_done_frame_id);
            if (rsp_slice_count !== want.slice_count)
               note_mismatch("slice_count", FID_W'(want.slice_count), FID_W'(rsp_slice_count));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
